@@ rtl/pdq_pkg.sv @@
// ----------------------------------------------------------------------------
// pdq_pkg
// Shared types and constants of the attitude controller and quad mixer.
// ----------------------------------------------------------------------------
package pdq_pkg;

	localparam int AXES            = 4;
	localparam int ANGLE_FRAC_BITS = 6;
	localparam int GAIN_FRAC_BITS  = 8;
	localparam int TERM_SHIFT      = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;

	localparam int MEAS_W = 15;
	localparam int REF_W  = 16;
	localparam int ERR_W  = 17;
	localparam int DIFF_W = 18;
	localparam int GAIN_W = 16;
	localparam int PE_W   = ERR_W + GAIN_W + 1;
	localparam int DE_W   = DIFF_W + GAIN_W + 1;
	localparam int ACC_W  = DE_W + 1;
	localparam int TERM_W = 16;
	localparam int MOTOR_W = 16;
	localparam int REG_IDX_W = 3;

	localparam logic [MOTOR_W-1:0] MOTOR_BIAS = 16'd1500;

	localparam logic [REG_IDX_W-1:0] REG_KP_ROLL  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KP_PITCH = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KP_YAW   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KP_LIFT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KD_ROLL  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_KD_PITCH = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_KD_YAW   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_KD_LIFT  = 3'd7;

	localparam logic [GAIN_W-1:0] KP_ATT_RESET  = 16'd640;
	localparam logic [GAIN_W-1:0] KP_LIFT_RESET = 16'd0;
	localparam logic [GAIN_W-1:0] KD_ATT_RESET  = 16'd5120;
	localparam logic [GAIN_W-1:0] KD_LIFT_RESET = 16'd0;

	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic [MOTOR_W-1:0] motor_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
		logic upd_prev;
	} lane_ctl_t;

	typedef struct packed {
		logic load;
		logic upd_hold;
		logic held;
	} mix_ctl_t;

endpackage

@@ rtl/pdq_lane.sv @@
// ----------------------------------------------------------------------------
// pdq_lane
// One axis lane: error, difference, gain products, sum and saturated term.
// ----------------------------------------------------------------------------
module pdq_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pdq_pkg::lane_ctl_t                  ctl,
	input  logic signed [pdq_pkg::MEAS_W-1:0]   meas,
	input  logic signed [pdq_pkg::REF_W-1:0]    setp,
	input  logic [pdq_pkg::GAIN_W-1:0]          kp,
	input  logic [pdq_pkg::GAIN_W-1:0]          kd,
	output logic signed [pdq_pkg::ERR_W-1:0]    err_s1,
	output logic signed [pdq_pkg::ERR_W-1:0]    prev_q,
	output pdq_pkg::term_t                      term_s5
);
	import pdq_pkg::*;

	logic signed [ERR_W-1:0]  err_s2;
	logic signed [DIFF_W-1:0] diff_s2;
	logic signed [PE_W-1:0]   pe_s3;
	logic signed [DE_W-1:0]   de_s3;
	logic signed [ACC_W-1:0]  acc_s4;
	logic signed [PE_W-1:0]   pe_next;
	logic signed [DE_W-1:0]   de_next;
	logic [ACC_W-1:0]         mag;
	logic [ACC_W-1:0]         mag_sh;
	term_t                    term_next;

	assign pe_next = PE_W'(err_s2) * $signed({1'b0, kp});
	assign de_next = DE_W'(diff_s2) * $signed({1'b0, kd});

	always_comb begin
		mag    = acc_s4[ACC_W-1] ? ACC_W'(-acc_s4) : ACC_W'(acc_s4);
		mag_sh = mag >> TERM_SHIFT;
		if (acc_s4[ACC_W-1]) begin
			if (mag_sh > ACC_W'(32768)) begin
				term_next = term_t'(16'h8000);
			end else begin
				term_next = term_t'(-mag_sh[TERM_W-1:0]);
			end
		end else begin
			if (mag_sh > ACC_W'(32767)) begin
				term_next = term_t'(16'h7fff);
			end else begin
				term_next = term_t'(mag_sh[TERM_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (ctl.upd_prev) begin
			prev_q <= err_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			err_s1 <= ERR_W'(setp) - ERR_W'(meas);
		end
		if (ctl.en_s2) begin
			err_s2  <= err_s1;
			diff_s2 <= DIFF_W'(err_s1) - DIFF_W'(prev_q);
		end
		if (ctl.en_s3) begin
			pe_s3 <= pe_next;
			de_s3 <= de_next;
		end
		if (ctl.en_s4) begin
			acc_s4 <= ACC_W'(pe_s3) + ACC_W'(de_s3);
		end
		if (ctl.en_s5) begin
			term_s5 <= term_next;
		end
	end

endmodule

@@ rtl/pdq_mixer.sv @@
// ----------------------------------------------------------------------------
// pdq_mixer
// Merges the four axis terms into motor pulses and holds the last values.
// ----------------------------------------------------------------------------
module pdq_mixer (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  pdq_pkg::mix_ctl_t                        ctl,
	input  pdq_pkg::term_t [pdq_pkg::AXES-1:0]       term,
	output pdq_pkg::motor_t [pdq_pkg::AXES-1:0]      motor_s6,
	output logic                                     held_s6
);
	import pdq_pkg::*;

	motor_t [AXES-1:0] mix;
	motor_t [AXES-1:0] held_motor_q;
	motor_t            t0;
	motor_t            t1;
	motor_t            t2;
	motor_t            t3;

	assign t0 = motor_t'(term[0]);
	assign t1 = motor_t'(term[1]);
	assign t2 = motor_t'(term[2]);
	assign t3 = motor_t'(term[3]);

	assign mix[0] = MOTOR_BIAS + t3 - t1 - t0 - t2;
	assign mix[1] = MOTOR_BIAS + t3 + t1 - t0 + t2;
	assign mix[2] = MOTOR_BIAS + t3 - t1 + t0 + t2;
	assign mix[3] = MOTOR_BIAS + t3 + t1 + t0 - t2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_motor_q <= '0;
		end else if (ctl.upd_hold) begin
			held_motor_q <= mix;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			motor_s6 <= ctl.held ? held_motor_q : mix;
			held_s6  <= ctl.held;
		end
	end

endmodule

@@ rtl/pd_attitude_quad_mixer.sv @@
// ----------------------------------------------------------------------------
// pd_attitude_quad_mixer
// PD attitude controller for four axes with an X-frame quadcopter mixer.
// ----------------------------------------------------------------------------
// The command channel carries one word per control step: four measured axis
// values and four references. The result channel returns one word per
// command: four motor pulses and a flag that marks repeated (held) pulses.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low.
// The datapath has six register stages. One command is taken every cycle
// while cmd_stall is low; the rate is set by the four axis lanes, each with
// its own pair of multipliers. When the receiver stalls, the result holds
// and the stages behind it keep filling until the pipeline is full, and only
// then is cmd_stall raised. Reset clears all stage valid bits, the stored
// previous errors and held pulses, and loads the default gains. Gains are
// written through the cfg port, one register per cycle; the user must write
// them only while no command is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
module pd_attitude_quad_mixer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pdq_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [pdq_pkg::GAIN_W-1:0]           cfg_data,
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  logic signed [pdq_pkg::MEAS_W-1:0]    meas_roll,
	input  logic signed [pdq_pkg::MEAS_W-1:0]    meas_pitch,
	input  logic signed [pdq_pkg::MEAS_W-1:0]    meas_yaw,
	input  logic signed [pdq_pkg::MEAS_W-1:0]    meas_lift,
	input  logic signed [pdq_pkg::REF_W-1:0]     ref_roll,
	input  logic signed [pdq_pkg::REF_W-1:0]     ref_pitch,
	input  logic signed [pdq_pkg::REF_W-1:0]     ref_yaw,
	input  logic signed [pdq_pkg::REF_W-1:0]     ref_lift,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic [pdq_pkg::MOTOR_W-1:0]          motor_front_a,
	output logic [pdq_pkg::MOTOR_W-1:0]          motor_front_b,
	output logic [pdq_pkg::MOTOR_W-1:0]          motor_rear_a,
	output logic [pdq_pkg::MOTOR_W-1:0]          motor_rear_b,
	output logic                                 held
);
	import pdq_pkg::*;

	logic [GAIN_W-1:0] kp_q [AXES];
	logic [GAIN_W-1:0] kd_q [AXES];

	logic signed [MEAS_W-1:0] meas_arr [AXES];
	logic signed [REF_W-1:0]  ref_arr  [AXES];
	logic signed [ERR_W-1:0]  err_s1   [AXES];
	logic signed [ERR_W-1:0]  prev_q   [AXES];
	term_t [AXES-1:0]         term_s5;
	motor_t [AXES-1:0]        motor_s6;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic held_now;
	logic held_s2, held_s3, held_s4, held_s5;
	lane_ctl_t lane_ctl;
	mix_ctl_t  mix_ctl;

	assign meas_arr[0] = meas_roll;
	assign meas_arr[1] = meas_pitch;
	assign meas_arr[2] = meas_yaw;
	assign meas_arr[3] = meas_lift;
	assign ref_arr[0]  = ref_roll;
	assign ref_arr[1]  = ref_pitch;
	assign ref_arr[2]  = ref_yaw;
	assign ref_arr[3]  = ref_lift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q[0] <= KP_ATT_RESET;
			kp_q[1] <= KP_ATT_RESET;
			kp_q[2] <= KP_ATT_RESET;
			kp_q[3] <= KP_LIFT_RESET;
			kd_q[0] <= KD_ATT_RESET;
			kd_q[1] <= KD_ATT_RESET;
			kd_q[2] <= KD_ATT_RESET;
			kd_q[3] <= KD_LIFT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP_ROLL:  kp_q[0] <= cfg_data;
				REG_KP_PITCH: kp_q[1] <= cfg_data;
				REG_KP_YAW:   kp_q[2] <= cfg_data;
				REG_KP_LIFT:  kp_q[3] <= cfg_data;
				REG_KD_ROLL:  kd_q[0] <= cfg_data;
				REG_KD_PITCH: kd_q[1] <= cfg_data;
				REG_KD_YAW:   kd_q[2] <= cfg_data;
				REG_KD_LIFT:  kd_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or when its word moves on.
	assign en_s6 = !v_s6 || !res_stall;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign cmd_stall = !en_s1;

	assign held_now = (err_s1[0] == prev_q[0]);

	always_comb begin
		lane_ctl.en_s1    = en_s1;
		lane_ctl.en_s2    = en_s2;
		lane_ctl.en_s3    = en_s3;
		lane_ctl.en_s4    = en_s4;
		lane_ctl.en_s5    = en_s5;
		lane_ctl.upd_prev = en_s2 && v_s1 && !held_now;
		mix_ctl.load      = en_s6;
		mix_ctl.upd_hold  = en_s6 && v_s5 && !held_s5;
		mix_ctl.held      = held_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= cmd_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) held_s2 <= held_now;
		if (en_s3) held_s3 <= held_s2;
		if (en_s4) held_s4 <= held_s3;
		if (en_s5) held_s5 <= held_s4;
	end

	for (genvar i = 0; i < AXES; i++) begin : g_lane
		pdq_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (lane_ctl),
			.meas    (meas_arr[i]),
			.setp    (ref_arr[i]),
			.kp      (kp_q[i]),
			.kd      (kd_q[i]),
			.err_s1  (err_s1[i]),
			.prev_q  (prev_q[i]),
			.term_s5 (term_s5[i])
		);
	end

	pdq_mixer u_mixer (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mix_ctl),
		.term     (term_s5),
		.motor_s6 (motor_s6),
		.held_s6  (held)
	);

	assign res_valid     = v_s6;
	assign motor_front_a = motor_s6[0];
	assign motor_front_b = motor_s6[1];
	assign motor_rear_a  = motor_s6[2];
	assign motor_rear_b  = motor_s6[3];

endmodule

@@ rtl/pdq_checker.sv @@
// ----------------------------------------------------------------------------
// pdq_checker
// Port-level checks of the attitude controller, bound to the top level.
// ----------------------------------------------------------------------------
module pdq_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	input  logic                                 cmd_stall,
	input  logic                                 res_valid,
	input  logic                                 res_stall,
	input  logic [pdq_pkg::MOTOR_W-1:0]          motor_front_a,
	input  logic [pdq_pkg::MOTOR_W-1:0]          motor_front_b,
	input  logic [pdq_pkg::MOTOR_W-1:0]          motor_rear_a,
	input  logic [pdq_pkg::MOTOR_W-1:0]          motor_rear_b,
	input  logic                                 held
);
	import pdq_pkg::*;

	logic [2:0]   inflight_q;
	logic         cmd_acc;
	logic         res_acc;
	logic [MOTOR_W-1:0] last_fa_q, last_fb_q, last_ra_q, last_rb_q;

	assign cmd_acc = cmd_valid && !cmd_stall;
	assign res_acc = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			last_fa_q  <= '0;
			last_fb_q  <= '0;
			last_ra_q  <= '0;
			last_rb_q  <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(cmd_acc) - 3'(res_acc);
			if (res_acc) begin
				last_fa_q <= motor_front_a;
				last_fb_q <= motor_front_b;
				last_ra_q <= motor_rear_a;
				last_rb_q <= motor_rear_b;
			end
		end
	end

	// A held word repeats the pulses of the word delivered before it.
	a_held_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && held |-> motor_front_a == last_fa_q && motor_front_b == last_fb_q &&
			motor_rear_a == last_ra_q && motor_rear_b == last_rb_q)
		else $error("held result does not repeat the last pulses");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> inflight_q != 3'd0)
		else $error("result without an accepted command");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 3'd7)
		else $error("more commands in flight than pipeline stages");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("command stalled while the result side is free");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(motor_front_a) && $stable(held))
		else $error("stalled result changed");

endmodule

bind pd_attitude_quad_mixer pdq_checker u_checker (.*);

@@ tb/sv/pulse_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_checker
// Watches the gain port and both channels of the attitude mixer, computes the
// motor pulses that each accepted command word must produce, and compares
// every accepted result word with the oldest pending prediction.
// ----------------------------------------------------------------------------
module pulse_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pdq_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [pdq_pkg::GAIN_W-1:0]         cfg_data,
	input  logic                               cmd_valid,
	input  logic                               cmd_stall,
	input  logic signed [pdq_pkg::MEAS_W-1:0]  meas_roll,
	input  logic signed [pdq_pkg::MEAS_W-1:0]  meas_pitch,
	input  logic signed [pdq_pkg::MEAS_W-1:0]  meas_yaw,
	input  logic signed [pdq_pkg::MEAS_W-1:0]  meas_lift,
	input  logic signed [pdq_pkg::REF_W-1:0]   ref_roll,
	input  logic signed [pdq_pkg::REF_W-1:0]   ref_pitch,
	input  logic signed [pdq_pkg::REF_W-1:0]   ref_yaw,
	input  logic signed [pdq_pkg::REF_W-1:0]   ref_lift,
	input  logic                               res_valid,
	input  logic                               res_stall,
	input  logic [pdq_pkg::MOTOR_W-1:0]        motor_front_a,
	input  logic [pdq_pkg::MOTOR_W-1:0]        motor_front_b,
	input  logic [pdq_pkg::MOTOR_W-1:0]        motor_rear_a,
	input  logic [pdq_pkg::MOTOR_W-1:0]        motor_rear_b,
	input  logic                               held,
	output int                                 pending,
	output int                                 errors
);
	import pdq_pkg::*;

	typedef struct packed {
		motor_t [AXES-1:0] pulse;
		logic              held;
	} pulses_t;

	logic [GAIN_W-1:0]       kp_gain [AXES];
	logic [GAIN_W-1:0]       kd_gain [AXES];
	logic signed [ERR_W-1:0] last_error [AXES];
	motor_t [AXES-1:0]       hold_pulse;
	pulses_t                 expected_pulses [$];
	int                      mismatch_cnt = 0;

	function automatic term_t scaled_term(longint e, longint d, logic [GAIN_W-1:0] kp,
			logic [GAIN_W-1:0] kd);
		longint kpl;
		longint kdl;
		longint acc;
		longint mag;
		kpl = kp;
		kdl = kd;
		acc = e * kpl + d * kdl;
		if (acc < 0) begin
			mag = (-acc) >> TERM_SHIFT;
			if (mag > 32768)
				mag = 32768;
			return term_t'(-mag);
		end
		mag = acc >> TERM_SHIFT;
		if (mag > 32767)
			mag = 32767;
		return term_t'(mag);
	endfunction

	// Uses the command payload on the ports and, unless the word is held, advances the controller state.
	function automatic pulses_t predict_pulses();
		pulses_t p;
		longint  err [AXES];
		term_t   t [AXES];
		int      mix [AXES];
		err[0] = longint'(ref_roll)  - longint'(meas_roll);
		err[1] = longint'(ref_pitch) - longint'(meas_pitch);
		err[2] = longint'(ref_yaw)   - longint'(meas_yaw);
		err[3] = longint'(ref_lift)  - longint'(meas_lift);
		if (err[0] == longint'(last_error[0])) begin
			p.pulse = hold_pulse;
			p.held  = 1'b1;
			return p;
		end
		for (int i = 0; i < AXES; i++) begin
			t[i] = scaled_term(err[i], err[i] - longint'(last_error[i]), kp_gain[i], kd_gain[i]);
			last_error[i] = err[i][ERR_W-1:0];
		end
		mix[0] = int'(t[3]) - int'(t[1]) - int'(t[0]) - int'(t[2]);
		mix[1] = int'(t[3]) + int'(t[1]) - int'(t[0]) + int'(t[2]);
		mix[2] = int'(t[3]) - int'(t[1]) + int'(t[0]) + int'(t[2]);
		mix[3] = int'(t[3]) + int'(t[1]) + int'(t[0]) - int'(t[2]);
		for (int i = 0; i < AXES; i++)
			p.pulse[i] = motor_t'(int'(MOTOR_BIAS) + mix[i]);
		p.held = 1'b0;
		hold_pulse = p.pulse;
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pulses_t want;
		pulses_t got;
		if (!arst_n) begin
			kp_gain[0] = KP_ATT_RESET;
			kp_gain[1] = KP_ATT_RESET;
			kp_gain[2] = KP_ATT_RESET;
			kp_gain[3] = KP_LIFT_RESET;
			kd_gain[0] = KD_ATT_RESET;
			kd_gain[1] = KD_ATT_RESET;
			kd_gain[2] = KD_ATT_RESET;
			kd_gain[3] = KD_LIFT_RESET;
			for (int i = 0; i < AXES; i++)
				last_error[i] = '0;
			hold_pulse = '0;
			expected_pulses.delete();
			pending <= 0;
			errors <= mismatch_cnt;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KP_ROLL:  kp_gain[0] = cfg_data;
					REG_KP_PITCH: kp_gain[1] = cfg_data;
					REG_KP_YAW:   kp_gain[2] = cfg_data;
					REG_KP_LIFT:  kp_gain[3] = cfg_data;
					REG_KD_ROLL:  kd_gain[0] = cfg_data;
					REG_KD_PITCH: kd_gain[1] = cfg_data;
					REG_KD_YAW:   kd_gain[2] = cfg_data;
					REG_KD_LIFT:  kd_gain[3] = cfg_data;
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall)
				expected_pulses.push_back(predict_pulses());
			if (res_valid && !res_stall) begin
				got.pulse[0] = motor_front_a;
				got.pulse[1] = motor_front_b;
				got.pulse[2] = motor_rear_a;
				got.pulse[3] = motor_rear_b;
				got.held     = held;
				if (expected_pulses.size() == 0) begin
					$display("%0t: result word with none expected, actual %h %h %h %h held %b",
						$time, got.pulse[0], got.pulse[1], got.pulse[2], got.pulse[3], got.held);
					mismatch_cnt++;
				end else begin
					want = expected_pulses.pop_front();
					for (int i = 0; i < AXES; i++) begin
						if (got.pulse[i] !== want.pulse[i]) begin
							$display("%0t: motor %0d expected %h actual %h",
								$time, i, want.pulse[i], got.pulse[i]);
							mismatch_cnt++;
						end
					end
					if (got.held !== want.held) begin
						$display("%0t: held expected %b actual %b", $time, want.held, got.held);
						mismatch_cnt++;
					end
				end
			end
			pending <= expected_pulses.size();
			errors <= mismatch_cnt;
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the attitude mixer with directed corner words and long runs of
// random attitude samples under several gain settings, with random gaps on
// the command side and random stalls on the result side. The checker beside
// the block does the prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import pdq_pkg::*;

	localparam int PHASES       = 6;
	localparam int PHASE_WORDS  = 280;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef logic signed [MEAS_W-1:0] meas_t;
	typedef logic signed [REF_W-1:0]  target_t;

	typedef struct packed {
		meas_t   [AXES-1:0] meas;
		target_t [AXES-1:0] target;
	} attitude_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]   cfg_data = '0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	meas_t               meas_roll = '0;
	meas_t               meas_pitch = '0;
	meas_t               meas_yaw = '0;
	meas_t               meas_lift = '0;
	target_t             ref_roll = '0;
	target_t             ref_pitch = '0;
	target_t             ref_yaw = '0;
	target_t             ref_lift = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	motor_t              motor_front_a;
	motor_t              motor_front_b;
	motor_t              motor_rear_a;
	motor_t              motor_rear_b;
	logic                held;
	int                  pending;
	int                  errors;
	int                  cycles = 0;
	bit                  calm = 1'b0;
	int                  stall_run = 0;
	int                  free_run = 0;
	longint              roll_err_sent = 0;

	pd_attitude_quad_mixer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.meas_roll(meas_roll), .meas_pitch(meas_pitch),
		.meas_yaw(meas_yaw), .meas_lift(meas_lift),
		.ref_roll(ref_roll), .ref_pitch(ref_pitch), .ref_yaw(ref_yaw), .ref_lift(ref_lift),
		.res_valid(res_valid), .res_stall(res_stall),
		.motor_front_a(motor_front_a), .motor_front_b(motor_front_b),
		.motor_rear_a(motor_rear_a), .motor_rear_b(motor_rear_b),
		.held(held)
	);

	pulse_checker u_pulse_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.meas_roll(meas_roll), .meas_pitch(meas_pitch),
		.meas_yaw(meas_yaw), .meas_lift(meas_lift),
		.ref_roll(ref_roll), .ref_pitch(ref_pitch), .ref_yaw(ref_yaw), .ref_lift(ref_lift),
		.res_valid(res_valid), .res_stall(res_stall),
		.motor_front_a(motor_front_a), .motor_front_b(motor_front_b),
		.motor_rear_a(motor_rear_a), .motor_rear_b(motor_rear_b),
		.held(held),
		.pending(pending), .errors(errors)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (!calm && stall_run > 0) begin
			res_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else if (calm || free_run > 0) begin
			res_stall <= 1'b0;
			if (free_run > 0)
				free_run <= free_run - 1;
		end else begin
			res_stall <= 1'b0;
			stall_run <= idle_len();
			free_run <= $urandom_range(0, 12);
		end
	end

	function automatic attitude_t mk(int mr, int mp, int my, int ml,
			int tr, int tp, int ty, int tl);
		attitude_t a;
		a.meas[0] = meas_t'(mr);
		a.meas[1] = meas_t'(mp);
		a.meas[2] = meas_t'(my);
		a.meas[3] = meas_t'(ml);
		a.target[0] = target_t'(tr);
		a.target[1] = target_t'(tp);
		a.target[2] = target_t'(ty);
		a.target[3] = target_t'(tl);
		return a;
	endfunction

	// Mostly plausible flight samples, some raw bit patterns, and a share of
	// words that repeat the previous roll error so that the hold path is hit.
	function automatic attitude_t next_attitude();
		attitude_t a;
		int        pick;
		int        m;
		int        d;
		int        e;
		int        lo;
		int        hi;
		pick = $urandom_range(0, 99);
		for (int i = 0; i < AXES; i++) begin
			if (pick < 20) begin
				a.meas[i] = meas_t'($urandom);
				a.target[i] = target_t'($urandom);
			end else if (pick < 35) begin
				m = $urandom_range(0, 128);
				m -= 64;
				d = $urandom_range(0, 16);
				d -= 8;
				a.meas[i] = meas_t'(m);
				a.target[i] = target_t'(m + d);
			end else begin
				m = $urandom_range(0, 23040);
				m -= 11520;
				if ($urandom_range(0, 3) == 0) begin
					d = $urandom_range(0, 40000);
					d -= 20000;
				end else begin
					d = $urandom_range(0, 1280);
					d -= 640;
				end
				a.meas[i] = meas_t'(m);
				a.target[i] = target_t'(m + d);
			end
		end
		if (pick >= 80) begin
			e = int'(roll_err_sent);
			lo = (-32768 - e > -16384) ? -32768 - e : -16384;
			hi = (32767 - e < 16383) ? 32767 - e : 16383;
			m = $urandom_range(0, hi - lo);
			m += lo;
			a.meas[0] = meas_t'(m);
			a.target[0] = target_t'(m + e);
		end
		return a;
	endfunction

	task automatic send_word(attitude_t a);
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		meas_roll <= a.meas[0];
		meas_pitch <= a.meas[1];
		meas_yaw <= a.meas[2];
		meas_lift <= a.meas[3];
		ref_roll <= a.target[0];
		ref_pitch <= a.target[1];
		ref_yaw <= a.target[2];
		ref_lift <= a.target[3];
		roll_err_sent = longint'($signed(a.target[0])) - longint'($signed(a.meas[0]));
		do
			@(posedge clk);
		while (cmd_stall);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_gain(logic [REG_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	task automatic set_gains(logic [GAIN_W-1:0] kpr, logic [GAIN_W-1:0] kpp,
			logic [GAIN_W-1:0] kpy, logic [GAIN_W-1:0] kpl, logic [GAIN_W-1:0] kdr,
			logic [GAIN_W-1:0] kdp, logic [GAIN_W-1:0] kdy, logic [GAIN_W-1:0] kdl);
		write_gain(REG_KP_ROLL, kpr);
		write_gain(REG_KP_PITCH, kpp);
		write_gain(REG_KP_YAW, kpy);
		write_gain(REG_KP_LIFT, kpl);
		write_gain(REG_KD_ROLL, kdr);
		write_gain(REG_KD_PITCH, kdp);
		write_gain(REG_KD_YAW, kdy);
		write_gain(REG_KD_LIFT, kdl);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default gains: a held word straight after reset, then full-scale words and small steps.
		send_word(mk(0, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(-16384, -16384, -16384, -16384, 32767, 32767, 32767, 32767));
		send_word(mk(16383, 16383, 16383, 16383, -32768, -32768, -32768, -32768));
		send_word(mk(16383, 16383, 16383, 16383, -32768, -32768, -32768, -32768));
		send_word(mk(11520, 11520, 11520, 11520, -23040, -23040, -23040, -23040));
		send_word(mk(-11520, -11520, -11520, -11520, 23040, 23040, 23040, 23040));
		send_word(mk(0, 0, 0, 0, 1, 0, 0, 0));
		send_word(mk(0, 0, 0, 0, 64, 64, 0, 0));
		send_word(mk(0, 0, 0, 0, 65, 0, 640, 0));
		send_word(mk(0, 0, 0, 0, 66, 0, 0, 640));
		wait_drained();

		set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_word(mk(-16384, -16384, -16384, -16384, 32767, 32767, 32767, 32767));
		send_word(mk(16383, 16383, 16383, 16383, -32768, -32768, -32768, -32768));
		send_word(mk(100, -200, 300, -400, 5, 5, 5, 5));
		send_word(mk(100, -200, 300, -400, 5, 5, 5, 5));
		wait_drained();

		set_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(mk(1, 2, 3, 4, -5, -6, -7, -8));
		send_word(mk(-20, 0, 0, 0, -26, 100, 100, 100));

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: set_gains(GAIN_W'($urandom_range(0, 1024)),
					GAIN_W'($urandom_range(0, 1024)),
					GAIN_W'($urandom_range(0, 1024)), GAIN_W'($urandom_range(0, 1024)),
					GAIN_W'($urandom_range(0, 8192)), GAIN_W'($urandom_range(0, 8192)),
					GAIN_W'($urandom_range(0, 8192)), GAIN_W'($urandom_range(0, 8192)));
				1: set_gains(GAIN_W'($urandom), GAIN_W'($urandom),
					GAIN_W'($urandom), GAIN_W'($urandom),
					GAIN_W'($urandom), GAIN_W'($urandom),
					GAIN_W'($urandom), GAIN_W'($urandom));
				2: set_gains(16'd640, 16'd640, 16'd640, GAIN_W'($urandom_range(1, 2048)),
					16'd5120, 16'd5120, 16'd5120, GAIN_W'($urandom_range(1, 2048)));
				3: set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					GAIN_W'($urandom), GAIN_W'($urandom),
					GAIN_W'($urandom), GAIN_W'($urandom));
				4: set_gains(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
					16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
				default: set_gains(GAIN_W'($urandom_range(0, 4096)), GAIN_W'($urandom),
					GAIN_W'($urandom_range(0, 4096)), GAIN_W'($urandom),
					GAIN_W'($urandom_range(0, 16384)), GAIN_W'($urandom_range(0, 16384)),
					GAIN_W'($urandom), GAIN_W'($urandom_range(0, 16384)));
			endcase
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 40 == 0)
					calm <= ($urandom_range(0, 3) == 0);
				send_word(next_attitude());
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
